>>> rtl/frame_refcount_engine_core_assert.svh
// Assertion macros shared by the frame reference count engine RTL.
// Plain text macros, no dependencies; included by modules that assert.
`ifndef FRAME_REFCOUNT_ENGINE_CORE_ASSERT_SVH
`define FRAME_REFCOUNT_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define FRC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frc assertion failed");

// next-cycle implication
`define FRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frc assertion failed");

`endif

>>> rtl/frc_pkg.sv
// Shared constants, command codes and transaction types of the frame
// reference count engine. No dependencies.
package frc_pkg;

   localparam int NUM_FRAMES = 4096;
   localparam int FRAME_W    = $clog2(NUM_FRAMES);
   localparam int BOUND_W    = FRAME_W + 1;
   localparam int MAX_RUN    = 256;
   localparam int RUN_W      = $clog2(MAX_RUN + 1);
   localparam int CNT_W      = 16;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [CMD_W-1:0] CMD_MARK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_HOLD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_ENABLE      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_LIMIT = 1'b1;

   typedef struct packed {
      logic                enabled;
      logic [BOUND_W-1:0]  bound;
      logic                rescan;
   } ctl_type;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [FRAME_W-1:0]  block_index;
      logic [RUN_W-1:0]    frames;
   } op_type;

   typedef struct packed {
      logic                used;
      logic [CNT_W-1:0]    count;
   } entry_type;

   typedef struct packed {
      logic [CNT_W-1:0]    ref_value;
      logic [RUN_W-1:0]    frames_freed;
      logic [BOUND_W-1:0]  avail_frames;
   } rsp_type;

endpackage

>>> rtl/frame_refcount_engine_core.sv
// Top level of the frame reference count engine: configuration registers,
// front end and back end. Depends on frc_pkg, frc_front, frc_back.
//
// channel   direction  handshake               payload
// req_      in         push / full             command, block_index, frame_count
// rsp_      out        empty / pop             ref_value, frames_freed, avail_frames
// csr_      in         we (no wait)            index, wdata
//
// In the back end a command does one read-modify-write of the frame store per
// managed frame; commands that touch no frame are answered without a read.
// After reset the store is cleared; a frame limit write recounts the used
// frames below the bound. req_full stays high during both.
// Two-entry queues on each side absorb stalls.
module frame_refcount_engine_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [frc_pkg::CMD_W-1:0]         req_command,
   input  logic [frc_pkg::FRAME_W-1:0]       req_block_index,
   input  logic [frc_pkg::RUN_W-1:0]         req_frame_count,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [frc_pkg::CNT_W-1:0]         rsp_ref_value,
   output logic [frc_pkg::RUN_W-1:0]         rsp_frames_freed,
   output logic [frc_pkg::BOUND_W-1:0]       rsp_avail_frames,
   input  logic                              csr_we,
   input  logic [frc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [frc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic                             enabled_ff;
   logic [frc_pkg::CSR_DATA_W-1:0]   frame_limit_ff;
   frc_pkg::ctl_type                 ctl;
   logic                             busy;
   logic                             op_valid;
   logic                             op_pop;
   frc_pkg::op_type                  op;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff     <= 1'b1;
         frame_limit_ff <= frc_pkg::CSR_DATA_W'(frc_pkg::NUM_FRAMES);
      end else if (csr_we) begin
         if (csr_index == frc_pkg::REG_ENABLE) begin
            enabled_ff <= csr_wdata[0];
         end
         if (csr_index == frc_pkg::REG_FRAME_LIMIT) begin
            frame_limit_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      ctl.enabled = enabled_ff;
      ctl.bound = (frc_pkg::BOUND_W'(frame_limit_ff) > frc_pkg::BOUND_W'(frc_pkg::NUM_FRAMES)) ?
                  frc_pkg::BOUND_W'(frc_pkg::NUM_FRAMES) : frc_pkg::BOUND_W'(frame_limit_ff);
      ctl.rescan = csr_we && (csr_index == frc_pkg::REG_FRAME_LIMIT);
   end

   frc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_block_index (req_block_index),
      .req_frame_count (req_frame_count),
      .ctl             (ctl),
      .busy            (busy),
      .op_valid        (op_valid),
      .op              (op),
      .op_pop          (op_pop)
   );

   frc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .op_valid         (op_valid),
      .op               (op),
      .op_pop           (op_pop),
      .busy             (busy),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_ref_value    (rsp_ref_value),
      .rsp_frames_freed (rsp_frames_freed),
      .rsp_avail_frames (rsp_avail_frames)
   );

endmodule

>>> rtl/frc_front.sv
// Front end: accepts request transactions, clips the run to managed frames
// and queues the resulting operation. Depends on frc_pkg.
module frc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [frc_pkg::CMD_W-1:0]      req_command,
   input  logic [frc_pkg::FRAME_W-1:0]    req_block_index,
   input  logic [frc_pkg::RUN_W-1:0]      req_frame_count,
   input  frc_pkg::ctl_type               ctl,
   input  logic                           busy,
   output logic                           op_valid,
   output frc_pkg::op_type                op,
   input  logic                           op_pop
);

   logic [frc_pkg::RUN_W-1:0]   len;
   logic                        in_range;
   logic [frc_pkg::BOUND_W-1:0] room;
   frc_pkg::op_type             op_new;
   logic                        push;

   frc_pkg::op_type q_ff [2];
   logic            wp_ff, wp_in;
   logic            rp_ff, rp_in;
   logic [1:0]      cnt_ff, cnt_in;

   always_comb begin
      len = (req_frame_count > frc_pkg::RUN_W'(frc_pkg::MAX_RUN)) ?
            frc_pkg::RUN_W'(frc_pkg::MAX_RUN) : req_frame_count;
      in_range = {1'b0, req_block_index} < ctl.bound;
      room = ctl.bound - {1'b0, req_block_index};
      op_new.command = req_command;
      op_new.block_index = req_block_index;
      if (req_command == frc_pkg::CMD_QUERY) begin
         op_new.frames = (ctl.enabled && in_range) ? frc_pkg::RUN_W'(1) : '0;
      end else if (!in_range) begin
         op_new.frames = '0;
      end else if (room < frc_pkg::BOUND_W'(len)) begin
         op_new.frames = room[frc_pkg::RUN_W-1:0];
      end else begin
         op_new.frames = len;
      end
   end

   assign req_full = (cnt_ff == 2'd2) || busy;
   assign push     = req_push && !req_full;
   assign op_valid = (cnt_ff != 2'd0);
   assign op       = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = op_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, op_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= op_new;
      end
   end

endmodule

>>> rtl/frc_back.sv
// Back end: frame store, clear and recount sweeps, per-frame
// read-modify-write sequencer and result queue. Depends on frc_pkg.
`include "frame_refcount_engine_core_assert.svh"

module frc_back (
   input  logic                            clock,
   input  logic                            reset,
   input  frc_pkg::ctl_type                ctl,
   input  logic                            op_valid,
   input  frc_pkg::op_type                 op,
   output logic                            op_pop,
   output logic                            busy,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [frc_pkg::CNT_W-1:0]       rsp_ref_value,
   output logic [frc_pkg::RUN_W-1:0]       rsp_frames_freed,
   output logic [frc_pkg::BOUND_W-1:0]     rsp_avail_frames
);

   localparam logic [1:0] ST_CLR  = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;
   localparam logic [1:0] ST_SCAN = 2'd3;

   frc_pkg::entry_type mem [frc_pkg::NUM_FRAMES];
   frc_pkg::entry_type rd_q;
   logic                        mem_we;
   logic [frc_pkg::FRAME_W-1:0] mem_wa;
   frc_pkg::entry_type          mem_wd;
   logic [frc_pkg::FRAME_W-1:0] rd_addr;

   logic [1:0]                  state_ff, state_in;
   logic [frc_pkg::BOUND_W-1:0] addr_ff, addr_in;
   logic [frc_pkg::RUN_W-1:0]   rem_ff, rem_in;
   logic [frc_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [frc_pkg::RUN_W-1:0]   freed_ff, freed_in;
   logic [frc_pkg::BOUND_W-1:0] used_total_ff, used_total_in;
   logic                        s2_valid_ff, s2_valid_in;
   logic [frc_pkg::FRAME_W-1:0] s2_addr_ff;
   logic                        s2_last_ff;

   logic                        issue_run, issue_scan, rd_en, restart;
   frc_pkg::entry_type          upd;
   logic [frc_pkg::CNT_W-1:0]   cnt_dec;
   logic                        drop, drop_used, mark_new;

   frc_pkg::rsp_type rq_ff [2];
   logic             rq_wp_ff, rq_rp_ff;
   logic [1:0]       rq_cnt_ff;
   logic             rsp_push, rsp_full, rq_pop;
   frc_pkg::rsp_type rsp_data;

   assign busy       = (state_ff == ST_CLR) || (state_ff == ST_SCAN);
   assign issue_run  = (state_ff == ST_RUN) && (rem_ff != '0);
   assign issue_scan = (state_ff == ST_SCAN) && (addr_ff < ctl.bound);
   assign rd_en      = issue_run || issue_scan;
   assign rd_addr    = addr_ff[frc_pkg::FRAME_W-1:0];
   assign restart    = ctl.rescan && (state_ff != ST_CLR);
   assign s2_valid_in = rd_en && !restart;

   // per-frame update of the entry read in the previous cycle
   always_comb begin
      upd      = rd_q;
      cnt_dec  = rd_q.count;
      drop     = 1'b0;
      case (cmd_ff)
         frc_pkg::CMD_MARK: begin
            upd.used = 1'b1;
            if (ctl.enabled) begin
               upd.count = frc_pkg::CNT_W'(1);
            end
         end
         frc_pkg::CMD_HOLD: begin
            if (ctl.enabled && rd_q.count != frc_pkg::CNT_MAX) begin
               upd.count = rd_q.count + frc_pkg::CNT_W'(1);
            end
         end
         frc_pkg::CMD_RELEASE: begin
            if (ctl.enabled && rd_q.count != '0) begin
               cnt_dec = rd_q.count - frc_pkg::CNT_W'(1);
            end
            drop = ctl.enabled ? (cnt_dec == '0) : 1'b1;
            upd.count = cnt_dec;
            upd.used  = rd_q.used && !drop;
         end
         default: begin
            upd = rd_q;
         end
      endcase
      drop_used = (cmd_ff == frc_pkg::CMD_RELEASE) && drop && rd_q.used;
      mark_new  = (cmd_ff == frc_pkg::CMD_MARK) && !rd_q.used;
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      rem_in        = rem_ff;
      cmd_in        = cmd_ff;
      freed_in      = freed_ff;
      used_total_in = used_total_ff;
      op_pop        = 1'b0;
      rsp_push      = 1'b0;
      rsp_data      = '0;
      mem_we        = 1'b0;
      mem_wa        = s2_addr_ff;
      mem_wd        = upd;
      case (state_ff)
         ST_CLR: begin
            mem_we  = 1'b1;
            mem_wa  = addr_ff[frc_pkg::FRAME_W-1:0];
            mem_wd  = '0;
            addr_in = addr_ff + frc_pkg::BOUND_W'(1);
            if (addr_ff == frc_pkg::BOUND_W'(frc_pkg::NUM_FRAMES - 1)) begin
               state_in = ST_IDLE;
               addr_in  = '0;
            end
         end
         ST_IDLE: begin
            if (op_valid && !rsp_full) begin
               op_pop = 1'b1;
               if (op.frames == '0) begin
                  rsp_push = 1'b1;
                  rsp_data.ref_value = (op.command == frc_pkg::CMD_QUERY) ?
                                       frc_pkg::CNT_W'(1) : '0;
                  rsp_data.avail_frames = ctl.bound - used_total_ff;
               end else begin
                  state_in = ST_RUN;
                  addr_in  = {1'b0, op.block_index};
                  rem_in   = op.frames;
                  cmd_in   = op.command;
                  freed_in = '0;
               end
            end
         end
         ST_RUN: begin
            if (issue_run) begin
               addr_in = addr_ff + frc_pkg::BOUND_W'(1);
               rem_in  = rem_ff - frc_pkg::RUN_W'(1);
            end
            if (s2_valid_ff) begin
               mem_we = (cmd_ff != frc_pkg::CMD_QUERY);
               used_total_in = used_total_ff + frc_pkg::BOUND_W'(mark_new)
                               - frc_pkg::BOUND_W'(drop_used);
               freed_in = freed_ff + frc_pkg::RUN_W'(drop_used);
               if (s2_last_ff) begin
                  rsp_push = 1'b1;
                  rsp_data.ref_value = (cmd_ff == frc_pkg::CMD_QUERY) ?
                                       rd_q.count : '0;
                  rsp_data.frames_freed = freed_in;
                  rsp_data.avail_frames = ctl.bound - used_total_in;
               end
            end else if (rem_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (issue_scan) begin
               addr_in = addr_ff + frc_pkg::BOUND_W'(1);
            end
            if (s2_valid_ff) begin
               used_total_in = used_total_ff + frc_pkg::BOUND_W'(rd_q.used);
            end
            if (!issue_scan && !s2_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLR;
            addr_in  = '0;
         end
      endcase
      if (restart) begin
         state_in      = ST_SCAN;
         addr_in       = '0;
         used_total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLR;
         addr_ff       <= '0;
         rem_ff        <= '0;
         cmd_ff        <= frc_pkg::CMD_MARK;
         freed_ff      <= '0;
         used_total_ff <= '0;
         s2_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         rem_ff        <= rem_in;
         cmd_ff        <= cmd_in;
         freed_ff      <= freed_in;
         used_total_ff <= used_total_in;
         s2_valid_ff   <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_addr_ff <= rd_addr;
      s2_last_ff <= issue_run && (rem_ff == frc_pkg::RUN_W'(1));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      rd_q <= mem[rd_addr];
   end

   // result queue
   assign rsp_full  = (rq_cnt_ff == 2'd2);
   assign rsp_empty = (rq_cnt_ff == 2'd0);
   assign rq_pop    = rsp_pop && !rsp_empty;
   assign rsp_ref_value    = rq_ff[rq_rp_ff].ref_value;
   assign rsp_frames_freed = rq_ff[rq_rp_ff].frames_freed;
   assign rsp_avail_frames = rq_ff[rq_rp_ff].avail_frames;

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wp_ff  <= 1'b0;
         rq_rp_ff  <= 1'b0;
         rq_cnt_ff <= 2'd0;
      end else begin
         rq_wp_ff  <= rsp_push ? !rq_wp_ff : rq_wp_ff;
         rq_rp_ff  <= rq_pop ? !rq_rp_ff : rq_rp_ff;
         rq_cnt_ff <= rq_cnt_ff + {1'b0, rsp_push} - {1'b0, rq_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rq_ff[rq_wp_ff] <= rsp_data;
      end
   end

   `FRC_ASSERT_IMPL(a_idle_drained, clock, reset, state_ff == ST_IDLE, !s2_valid_ff)
   `FRC_ASSERT_IMPL(a_rsp_room, clock, reset, rsp_push, !rsp_full)
   `FRC_ASSERT_NEXT(a_read_tracked, clock, reset, rd_en && !ctl.rescan, s2_valid_ff)
   `FRC_ASSERT_IMPL(a_used_bound, clock, reset, state_ff == ST_IDLE, used_total_ff <= ctl.bound)

endmodule
